@@ hw/rtl/tft_pkg.sv @@
// Shared types and constants of the TCP flow table responder.
// No dependencies; imported by every other file of the block but tft_stream_if.
`timescale 1ns / 1ps
package tft_pkg;

    localparam logic [1:0] OP_CLIENT = 2'd0;
    localparam logic [1:0] OP_SDATA  = 2'd1;
    localparam logic [1:0] OP_SFAIL  = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] ACT_PKT    = 2'd0;
    localparam logic [1:0] ACT_FWD    = 2'd1;
    localparam logic [1:0] ACT_CLOSED = 2'd2;

    localparam logic [7:0] F_FIN = 8'h01;
    localparam logic [7:0] F_SYN = 8'h02;
    localparam logic [7:0] F_RST = 8'h04;
    localparam logic [7:0] F_PSH = 8'h08;
    localparam logic [7:0] F_ACK = 8'h10;

    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam logic [1:0] REG_IDLE_LIMIT  = 2'd0;
    localparam logic [1:0] REG_WINDOW_SIZE = 2'd1;
    localparam logic [1:0] REG_INITIAL_SEQ = 2'd2;

    localparam logic [15:0] IDLE_LIMIT_RST  = 16'd120;
    localparam logic [15:0] WINDOW_SIZE_RST = 16'd65535;
    localparam logic [31:0] INITIAL_SEQ_RST = 32'd1;

    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  proto;
        logic [7:0]  seg_flags;
        logic [31:0] seq_num;
        logic [15:0] payload_len;
        logic [5:0]  conn_index;
        logic        server_ok;
        logic [31:0] now_time;
    } item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  entry_index;
        logic [31:0] reply_src_addr;
        logic [31:0] reply_dst_addr;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dst_port;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [7:0]  reply_flags;
        logic [15:0] reply_window;
        logic [15:0] out_len;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] value;
    } cfg_beat_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] exp_seq;
        logic [31:0] our_seq;
        logic [31:0] last_seen;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_CLOSE,
        ST_DACK,
        ST_SRV_CAP,
        ST_SRV_ACT,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_TICK_LAST
    } state_t;

    typedef enum logic [3:0] {
        RES_SYNACK,
        RES_RSTACK,
        RES_CFIN,
        RES_CLOSED,
        RES_FWD,
        RES_DACK,
        RES_PSH,
        RES_SFIN,
        RES_PEND
    } res_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SYN,
        WR_SEEN,
        WR_DATA,
        WR_PSH
    } wr_t;

    typedef enum logic [1:0] {
        U_NONE,
        U_SYN,
        U_CLR_HIT,
        U_CLR_SCAN
    } used_t;

    typedef struct packed {
        logic  load;
        logic  scan_init;
        logic  srv_sel;
        logic  rd_scan;
        logic  cmp;
        logic  idx_inc;
        logic  cap_ent;
        logic  tick_free;
        logic  emit;
        res_t  res;
        logic  last;
        wr_t   wr;
        used_t used;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       proto_tcp;
        logic       syn;
        logic       fin;
        logic       rst_or_fin;
        logic       ok;
        logic       plen_zero;
        logic       ci_ok;
        logic       hit;
        logic       free_found;
        logic       match;
        logic       data_ok;
        logic       last_idx;
        logic       idx_used;
        logic       expired;
        logic       pend_valid;
        logic       cnt_full;
        logic       out_free;
    } status_t;

endpackage

@@ hw/rtl/tft_stream_if.sv @@
// Valid/ready channel carrying one payload beat.
// Payload type is a parameter; used with the types of tft_pkg.
`timescale 1ns / 1ps
interface tft_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/tft_ctrl.sv @@
// Sequencer of the flow table: decodes each item and steers the datapath.
// Depends on tft_pkg.
`timescale 1ns / 1ps
module tft_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tft_pkg::status_t st,
    output tft_pkg::cmd_t    cmd
);
    import tft_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res    = RES_CLOSED;
        cmd.wr     = WR_NONE;
        cmd.used   = U_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (st.op)
                    OP_CLIENT:
                    begin
                        if (st.proto_tcp)
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = ST_SCAN_RD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_SDATA, OP_SFAIL:
                    begin
                        if (st.ci_ok && !(st.op == OP_SDATA && st.plen_zero))
                        begin
                            cmd.srv_sel = 1'b1;
                            state_next  = ST_SRV_CAP;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_TICK_RD;
                    end
                endcase
            end
            ST_SCAN_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                cmd.cmp = 1'b1;
                if (st.match || st.last_idx)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_DECIDE:
            begin
                if (st.syn)
                begin
                    if (st.hit || !st.free_found)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (st.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.res    = st.ok ? RES_SYNACK : RES_RSTACK;
                        cmd.last   = 1'b1;
                        cmd.wr     = WR_SYN;
                        cmd.used   = U_SYN;
                        state_next = ST_IDLE;
                    end
                end
                else if (!st.hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.rst_or_fin)
                begin
                    if (!st.fin)
                    begin
                        state_next = ST_CLOSE;
                    end
                    else if (st.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.res    = RES_CFIN;
                        state_next = ST_CLOSE;
                    end
                end
                else if (!st.data_ok)
                begin
                    cmd.wr     = WR_SEEN;
                    state_next = ST_IDLE;
                end
                else if (!st.ok)
                begin
                    state_next = ST_CLOSE;
                end
                else if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.res    = RES_FWD;
                    cmd.wr     = WR_DATA;
                    state_next = ST_DACK;
                end
            end
            ST_CLOSE:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.res    = RES_CLOSED;
                    cmd.last   = 1'b1;
                    cmd.used   = U_CLR_HIT;
                    state_next = ST_IDLE;
                end
            end
            ST_DACK:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.res    = RES_DACK;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SRV_CAP:
            begin
                cmd.cap_ent = 1'b1;
                state_next  = ST_SRV_ACT;
            end
            ST_SRV_ACT:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.op == OP_SDATA)
                    begin
                        cmd.res    = RES_PSH;
                        cmd.last   = 1'b1;
                        cmd.wr     = WR_PSH;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.res    = RES_SFIN;
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_TICK_RD:
            begin
                if (st.idx_used)
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = ST_TICK_CMP;
                end
                else if (st.last_idx)
                begin
                    state_next = ST_TICK_LAST;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_TICK_CMP:
            begin
                if (!st.expired)
                begin
                    if (st.last_idx)
                    begin
                        state_next = ST_TICK_LAST;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_TICK_RD;
                    end
                end
                else if (!st.pend_valid || st.out_free)
                begin
                    cmd.emit      = st.pend_valid;
                    cmd.res       = RES_PEND;
                    cmd.tick_free = 1'b1;
                    cmd.used      = U_CLR_SCAN;
                    if (st.cnt_full || st.last_idx)
                    begin
                        state_next = ST_TICK_LAST;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_TICK_RD;
                    end
                end
            end
            ST_TICK_LAST:
            begin
                if (!st.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.res    = RES_PEND;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/tft_datapath.sv @@
// Flow table memory, used bits, config registers, scan index and result register.
// Depends on tft_pkg; driven by tft_ctrl commands.
`timescale 1ns / 1ps
module tft_datapath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tft_pkg::item_t     in_data,
    input  logic               cfg_valid,
    input  tft_pkg::cfg_beat_t cfg_data,
    input  tft_pkg::cmd_t      cmd,
    output tft_pkg::status_t   st,
    output logic               out_valid,
    input  logic               out_ready,
    output tft_pkg::result_t   out_data
);
    import tft_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int XW = IW + 6;

    item_t     item_reg;
    logic [15:0] idle_limit_reg;
    logic [15:0] window_reg;
    logic [31:0] init_seq_reg;

    entry_t    mem [TABLE_ENTRIES];
    entry_t    rdata_reg;
    entry_t    ent_reg;
    entry_t    pend_reg;
    entry_t    wr_data;

    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [IW-1:0] free_idx_reg;
    logic [IW-1:0] pend_idx_reg;
    logic [IW-1:0] ci_idx;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] res_idx;
    logic [XW-1:0] ci_wide;
    logic [XW-1:0] res_idx_wide;
    logic          hit_reg;
    logic          free_found_reg;
    logic          pend_valid_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic          out_valid_reg;
    result_t       out_reg;
    result_t       res;
    logic [31:0]   seq_plus1;
    logic [31:0]   plen_ext;

    assign ci_wide   = XW'(item_reg.conn_index);
    assign ci_idx    = ci_wide[IW-1:0];
    assign seq_plus1 = item_reg.seq_num + 32'd1;
    assign plen_ext  = {16'b0, item_reg.payload_len};
    assign rd_addr   = cmd.srv_sel ? ci_idx : idx_reg;
    assign wr_addr   = (cmd.wr == WR_SYN) ? free_idx_reg : hit_idx_reg;

    always_comb
    begin
        st            = '0;
        st.op         = item_reg.operation;
        st.proto_tcp  = item_reg.proto == PROTO_TCP;
        st.syn        = (item_reg.seg_flags & F_SYN) != 8'd0;
        st.fin        = (item_reg.seg_flags & F_FIN) != 8'd0;
        st.rst_or_fin = (item_reg.seg_flags & (F_RST | F_FIN)) != 8'd0;
        st.ok         = item_reg.server_ok;
        st.plen_zero  = item_reg.payload_len == 16'd0;
        st.ci_ok      = (ci_wide < XW'(TABLE_ENTRIES)) && used_reg[ci_idx];
        st.hit        = hit_reg;
        st.free_found = free_found_reg;
        st.match      = used_reg[idx_reg]
                        && rdata_reg.src_addr == item_reg.src_addr
                        && rdata_reg.dst_addr == item_reg.dst_addr
                        && rdata_reg.src_port == item_reg.src_port
                        && rdata_reg.dst_port == item_reg.dst_port;
        st.data_ok    = !st.plen_zero && item_reg.seq_num == ent_reg.exp_seq;
        st.last_idx   = idx_reg == IW'(TABLE_ENTRIES - 1);
        st.idx_used   = used_reg[idx_reg];
        st.expired    = (item_reg.now_time - rdata_reg.last_seen) > {16'b0, idle_limit_reg};
        st.pend_valid = pend_valid_reg;
        st.cnt_full   = cnt_reg == CNT_W'(MAX_RESULTS - 1);
        st.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        wr_data = ent_reg;
        case (cmd.wr)
            WR_SYN:
            begin
                wr_data.src_addr  = item_reg.src_addr;
                wr_data.dst_addr  = item_reg.dst_addr;
                wr_data.src_port  = item_reg.src_port;
                wr_data.dst_port  = item_reg.dst_port;
                wr_data.exp_seq   = seq_plus1;
                wr_data.our_seq   = item_reg.server_ok ? init_seq_reg + 32'd1 : init_seq_reg;
                wr_data.last_seen = item_reg.now_time;
            end
            WR_SEEN:
            begin
                wr_data.last_seen = item_reg.now_time;
            end
            WR_DATA:
            begin
                wr_data.exp_seq   = ent_reg.exp_seq + plen_ext;
                wr_data.last_seen = item_reg.now_time;
            end
            WR_PSH:
            begin
                wr_data.our_seq = ent_reg.our_seq + plen_ext;
            end
            default:
            begin
                wr_data = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr != WR_NONE)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_scan || cmd.srv_sel)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        res                = '0;
        res.last_result    = cmd.last;
        res.reply_src_addr = ent_reg.dst_addr;
        res.reply_dst_addr = ent_reg.src_addr;
        res.reply_src_port = ent_reg.dst_port;
        res.reply_dst_port = ent_reg.src_port;
        res_idx            = hit_idx_reg;
        case (cmd.res)
            RES_SYNACK, RES_RSTACK:
            begin
                res_idx            = free_idx_reg;
                res.reply_src_addr = item_reg.dst_addr;
                res.reply_dst_addr = item_reg.src_addr;
                res.reply_src_port = item_reg.dst_port;
                res.reply_dst_port = item_reg.src_port;
                res.action         = ACT_PKT;
                res.reply_ack      = seq_plus1;
                if (cmd.res == RES_SYNACK)
                begin
                    res.reply_seq    = init_seq_reg;
                    res.reply_flags  = F_SYN | F_ACK;
                    res.reply_window = window_reg;
                end
                else
                begin
                    res.reply_flags = F_RST | F_ACK;
                end
            end
            RES_CFIN:
            begin
                res.action      = ACT_PKT;
                res.reply_seq   = ent_reg.our_seq;
                res.reply_ack   = seq_plus1;
                res.reply_flags = F_ACK | F_FIN;
            end
            RES_FWD:
            begin
                res.action  = ACT_FWD;
                res.out_len = item_reg.payload_len;
            end
            RES_DACK:
            begin
                res.action       = ACT_PKT;
                res.reply_seq    = ent_reg.our_seq;
                res.reply_ack    = ent_reg.exp_seq + plen_ext;
                res.reply_flags  = F_ACK;
                res.reply_window = window_reg;
            end
            RES_PSH:
            begin
                res.action       = ACT_PKT;
                res.reply_seq    = ent_reg.our_seq;
                res.reply_ack    = ent_reg.exp_seq;
                res.reply_flags  = F_ACK | F_PSH;
                res.reply_window = window_reg;
                res.out_len      = item_reg.payload_len;
            end
            RES_SFIN:
            begin
                res.action      = ACT_PKT;
                res.reply_seq   = ent_reg.our_seq;
                res.reply_ack   = ent_reg.exp_seq;
                res.reply_flags = F_FIN | F_ACK;
            end
            RES_PEND:
            begin
                res_idx            = pend_idx_reg;
                res.action         = ACT_CLOSED;
                res.reply_src_addr = pend_reg.dst_addr;
                res.reply_dst_addr = pend_reg.src_addr;
                res.reply_src_port = pend_reg.dst_port;
                res.reply_dst_port = pend_reg.src_port;
            end
            default:
            begin
                res.action = ACT_CLOSED;
            end
        endcase
        res_idx_wide    = XW'(res_idx);
        res.entry_index = res_idx_wide[5:0];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.cmp && st.match)
        begin
            ent_reg     <= rdata_reg;
            hit_idx_reg <= idx_reg;
        end
        else if (cmd.srv_sel)
        begin
            hit_idx_reg <= ci_idx;
        end
        if (cmd.cap_ent)
        begin
            ent_reg <= rdata_reg;
        end
        if (cmd.cmp && !used_reg[idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= idx_reg;
        end
        if (cmd.tick_free)
        begin
            pend_reg     <= rdata_reg;
            pend_idx_reg <= idx_reg;
        end
        if (cmd.emit)
        begin
            out_reg <= res;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RST;
            window_reg     <= WINDOW_SIZE_RST;
            init_seq_reg   <= INITIAL_SEQ_RST;
            used_reg       <= '0;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_data.index)
                    REG_IDLE_LIMIT:  idle_limit_reg <= cfg_data.value[15:0];
                    REG_WINDOW_SIZE: window_reg     <= cfg_data.value[15:0];
                    REG_INITIAL_SEQ: init_seq_reg   <= cfg_data.value;
                    default:         idle_limit_reg <= idle_limit_reg;
                endcase
            end
            if (cmd.scan_init)
            begin
                idx_reg        <= '0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
                pend_valid_reg <= 1'b0;
                cnt_reg        <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.cmp && st.match)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.cmp && !used_reg[idx_reg])
            begin
                free_found_reg <= 1'b1;
            end
            if (cmd.tick_free)
            begin
                pend_valid_reg <= 1'b1;
                cnt_reg        <= cnt_reg + CNT_W'(1);
            end
            case (cmd.used)
                U_SYN:      used_reg[free_idx_reg] <= item_reg.server_ok;
                U_CLR_HIT:  used_reg[hit_idx_reg]  <= 1'b0;
                U_CLR_SCAN: used_reg[idx_reg]      <= 1'b0;
                default:    used_reg               <= used_reg;
            endcase
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hw/rtl/tcp_flow_table_responder_unit.sv @@
// Top level of the TCP flow table responder: sequencer plus datapath.
// Depends on tft_pkg, tft_stream_if, tft_ctrl and tft_datapath.
//
// Channels: items (input segments, server events, ticks), results (reply
// headers, forward and flow-closed beats, last_result marks the final beat
// of an item) and cfg (register writes, always ready, idle block only).
// One item is worked at a time; items.ready is high only when idle.
// A client segment scans the table through the single memory read port,
// reading and then comparing each entry until a hit or the last entry.
// Server data captures the entry and then replies; a server failure also
// goes on to close the flow. A tick skips free entries and reads and checks
// used ones, one freed entry held back so the last beat can be marked.
// Results sit in one output register; the next item is taken while it
// waits, and the sequencer stalls only when it has a new beat to load.
// Reset clears the used bits and loads the config defaults; no memory
// sweep is needed, so items are taken right after reset.
`timescale 1ns / 1ps
module tcp_flow_table_responder_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    tft_stream_if.sink          items,
    tft_stream_if.source        results,
    tft_stream_if.sink          cfg
);
    import tft_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg.ready = 1'b1;

    tft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .st       (st),
        .cmd      (cmd)
    );

    tft_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (items.data),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (results.data)
    );

endmodule

@@ hw/rtl/tft_checker.sv @@
// Port-level assertions for the TCP flow table responder, bound to the top.
// Depends on tft_pkg and tcp_flow_table_responder_unit.
`timescale 1ns / 1ps
module tft_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input tft_pkg::result_t out_data,
    input logic             cfg_ready
);
    import tft_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

    a_fwd_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action == ACT_FWD |-> !out_data.last_result)
        else $error("forward beat marked last");

    a_closed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action == ACT_CLOSED
        |-> out_data.reply_flags == 8'd0 && out_data.reply_window == 16'd0
            && out_data.out_len == 16'd0)
        else $error("flow-closed beat carries header data");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> cfg_ready)
        else $error("config port blocked while idle");

endmodule

bind tcp_flow_table_responder_unit tft_checker u_tft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.data),
    .cfg_ready (cfg.ready)
);
